// ===== hw/rtl/tlca_pkg.sv =====
// Shared types, constants and the control program of the tree LCA block.
// Used by tlca_seq, tlca_dp and tree_lowest_common_ancestor; no dependencies.
package tlca_pkg;

	localparam int NODE_W  = 10;
	localparam int DEPTH_W = 10;
	localparam int STEP_W  = 4;

	// Program step addresses
	localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
	localparam logic [STEP_W-1:0] ST_LD_START = 4'd1;
	localparam logic [STEP_W-1:0] ST_LD_ROW   = 4'd2;
	localparam logic [STEP_W-1:0] ST_LD_END   = 4'd3;
	localparam logic [STEP_W-1:0] ST_Q_DEPTH  = 4'd4;
	localparam logic [STEP_W-1:0] ST_Q_ORDER  = 4'd5;
	localparam logic [STEP_W-1:0] ST_Q_LIFT   = 4'd6;
	localparam logic [STEP_W-1:0] ST_Q_SETTLE = 4'd7;
	localparam logic [STEP_W-1:0] ST_Q_CLIMB  = 4'd8;
	localparam logic [STEP_W-1:0] ST_Q_PARENT = 4'd9;
	localparam logic [STEP_W-1:0] ST_Q_TAKE   = 4'd10;
	localparam logic [STEP_W-1:0] ST_EMIT     = 4'd11;

	typedef enum logic [3:0] {
		ACT_NONE     = 4'd0,
		ACT_LD_START = 4'd1,
		ACT_LD_ROW   = 4'd2,
		ACT_Q_DEPTH  = 4'd3,
		ACT_Q_ORDER  = 4'd4,
		ACT_Q_LIFT   = 4'd5,
		ACT_Q_SETTLE = 4'd6,
		ACT_Q_CLIMB  = 4'd7,
		ACT_Q_PARENT = 4'd8,
		ACT_Q_TAKE   = 4'd9,
		ACT_EMIT     = 4'd10
	} act_t;

	typedef enum logic [2:0] {
		JMP_NEXT       = 3'd0,
		JMP_GOTO       = 3'd1,
		JMP_ACCEPT     = 3'd2,
		JMP_UNTIL_TOP  = 3'd3,
		JMP_UNTIL_ZERO = 3'd4,
		JMP_IF_SAME    = 3'd5,
		JMP_EMIT       = 3'd6
	} jmp_t;

	typedef enum logic [2:0] {
		LV_HOLD = 3'd0,
		LV_ONE  = 3'd1,
		LV_TOP  = 3'd2,
		LV_INC  = 3'd3,
		LV_DEC  = 3'd4
	} lvl_op_t;

	typedef struct packed {
		act_t              act;
		jmp_t              jmp;
		lvl_op_t           lvl_op;
		logic [STEP_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic same;
	} dp_stat_t;

	// Control store: one word per step
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		case (step)
			ST_IDLE:     w = '{ACT_NONE,     JMP_ACCEPT,     LV_HOLD, ST_Q_DEPTH};
			ST_LD_START: w = '{ACT_LD_START, JMP_NEXT,       LV_ONE,  ST_IDLE};
			ST_LD_ROW:   w = '{ACT_LD_ROW,   JMP_UNTIL_TOP,  LV_INC,  ST_LD_ROW};
			ST_LD_END:   w = '{ACT_NONE,     JMP_GOTO,       LV_HOLD, ST_IDLE};
			ST_Q_DEPTH:  w = '{ACT_Q_DEPTH,  JMP_NEXT,       LV_HOLD, ST_IDLE};
			ST_Q_ORDER:  w = '{ACT_Q_ORDER,  JMP_NEXT,       LV_TOP,  ST_IDLE};
			ST_Q_LIFT:   w = '{ACT_Q_LIFT,   JMP_UNTIL_ZERO, LV_DEC,  ST_Q_LIFT};
			ST_Q_SETTLE: w = '{ACT_Q_SETTLE, JMP_IF_SAME,    LV_TOP,  ST_EMIT};
			ST_Q_CLIMB:  w = '{ACT_Q_CLIMB,  JMP_UNTIL_ZERO, LV_DEC,  ST_Q_CLIMB};
			ST_Q_PARENT: w = '{ACT_Q_PARENT, JMP_NEXT,       LV_HOLD, ST_IDLE};
			ST_Q_TAKE:   w = '{ACT_Q_TAKE,   JMP_NEXT,       LV_HOLD, ST_IDLE};
			ST_EMIT:     w = '{ACT_EMIT,     JMP_EMIT,       LV_HOLD, ST_IDLE};
			default:     w = '{ACT_NONE,     JMP_GOTO,       LV_HOLD, ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/tlca_seq.sv =====
// Microcode sequencer: step counter, level counter and jump logic over the
// control store in tlca_pkg.
module tlca_seq
	import tlca_pkg::*;
#(
	parameter int LEVELS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          op,
	input  logic                          out_free,
	input  dp_stat_t                      stat,
	output act_t                          act,
	output logic [$clog2(LEVELS)-1:0]     lvl,
	output logic                          idle
);

	localparam int LW = $clog2(LEVELS);
	localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [LW-1:0]     lvl_q;
	logic [LW-1:0]     lvl_d;
	uword_t            uw;

	assign uw   = ucode(step_q);
	assign act  = uw.act;
	assign lvl  = lvl_q;
	assign idle = (step_q == ST_IDLE);

	always_comb begin
		case (uw.jmp)
			JMP_NEXT:       step_d = step_q + 1'b1;
			JMP_GOTO:       step_d = uw.target;
			JMP_ACCEPT:     step_d = !accept ? step_q : (op ? uw.target : step_q + 1'b1);
			JMP_UNTIL_TOP:  step_d = (lvl_q == LVL_TOP) ? step_q + 1'b1 : uw.target;
			JMP_UNTIL_ZERO: step_d = (lvl_q == '0) ? step_q + 1'b1 : uw.target;
			JMP_IF_SAME:    step_d = stat.same ? uw.target : step_q + 1'b1;
			JMP_EMIT:       step_d = out_free ? uw.target : step_q;
			default:        step_d = ST_IDLE;
		endcase
	end

	always_comb begin
		case (uw.lvl_op)
			LV_HOLD: lvl_d = lvl_q;
			LV_ONE:  lvl_d = LW'(1);
			LV_TOP:  lvl_d = LVL_TOP;
			LV_INC:  lvl_d = lvl_q + 1'b1;
			LV_DEC:  lvl_d = lvl_q - 1'b1;
			default: lvl_d = lvl_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			lvl_q  <= '0;
		end else begin
			step_q <= step_d;
			lvl_q  <= lvl_d;
		end
	end

endmodule

// ===== hw/rtl/tlca_dp.sv =====
// Datapath: node registers, depth and ancestor memories, lift and climb
// selection. Driven by the action code from tlca_seq; uses tlca_pkg.
module tlca_dp
	import tlca_pkg::*;
#(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [NODE_W-1:0]         in_a,
	input  logic [NODE_W-1:0]         in_b,
	input  act_t                      act,
	input  logic [$clog2(LEVELS)-1:0] lvl,
	output dp_stat_t                  stat,
	output logic [NODE_W-1:0]         result
);

	localparam int AW     = $clog2(NODES);
	localparam int LW     = $clog2(LEVELS);
	localparam int ADEPTH = NODES * (2 ** LW);

	logic [NODE_W-1:0]  anc_mem [ADEPTH];
	logic [DEPTH_W-1:0] dep_mem [NODES];

	logic [NODE_W-1:0]  x_q, y_q, x_d, y_d;
	logic [LEVELS-1:0]  delta_q, delta_d;
	logic               pend_q, pend_d;

	logic [NODE_W-1:0]  anc_rd_a_q, anc_rd_b_q;
	logic               anc_za_q, anc_zb_q;
	logic [DEPTH_W-1:0] dep_rd_a_q, dep_rd_b_q;
	logic               dep_za_q, dep_zb_q;

	logic [NODE_W-1:0]  ra, rb;
	logic [DEPTH_W-1:0] da, db;
	logic [NODE_W-1:0]  lift_a, climb_a, climb_b;
	logic               climb_hit;
	logic               ld_ok;

	logic               anc_re_a, anc_re_b, anc_we;
	logic [NODE_W-1:0]  anc_ra_node, anc_rb_node, anc_wd;
	logic [LW-1:0]      anc_rlvl, anc_wlvl;
	logic               dep_re, dep_we;
	logic [NODE_W-1:0]  dep_ra_node, dep_rb_node;
	logic [DEPTH_W-1:0] dep_wd;

	// Node 0 is the null node: its depth and ancestors read as zero
	assign ra = anc_za_q ? '0 : anc_rd_a_q;
	assign rb = anc_zb_q ? '0 : anc_rd_b_q;
	assign da = dep_za_q ? '0 : dep_rd_a_q;
	assign db = dep_zb_q ? '0 : dep_rd_b_q;

	assign ld_ok     = (x_q != '0);
	assign lift_a    = pend_q ? ra : x_q;
	assign climb_hit = pend_q && (ra != rb);
	assign climb_a   = climb_hit ? ra : x_q;
	assign climb_b   = climb_hit ? rb : y_q;

	assign stat.same = (lift_a == y_q);
	assign result    = x_q;

	always_comb begin
		x_d         = x_q;
		y_d         = y_q;
		delta_d     = delta_q;
		pend_d      = pend_q;
		anc_re_a    = 1'b0;
		anc_re_b    = 1'b0;
		anc_ra_node = x_q;
		anc_rb_node = y_q;
		anc_rlvl    = lvl;
		anc_we      = 1'b0;
		anc_wlvl    = lvl;
		anc_wd      = y_q;
		dep_re      = 1'b0;
		dep_ra_node = x_q;
		dep_rb_node = y_q;
		dep_we      = 1'b0;
		dep_wd      = (y_q == '0) ? DEPTH_W'(1) : da + 1'b1;
		case (act)
			ACT_LD_START: begin
				dep_re      = 1'b1;
				dep_ra_node = y_q;
				anc_re_a    = 1'b1;
				anc_ra_node = y_q;
				anc_rlvl    = '0;
				anc_we      = ld_ok;
				anc_wlvl    = '0;
				anc_wd      = y_q;
			end
			ACT_LD_ROW: begin
				// Write row[lvl] and fetch its lvl-th ancestor; the read sees
				// the old entry on a same-address collision
				anc_we      = ld_ok;
				anc_wd      = ra;
				anc_re_a    = 1'b1;
				anc_ra_node = ra;
				dep_we      = ld_ok;
			end
			ACT_Q_DEPTH: begin
				dep_re = 1'b1;
			end
			ACT_Q_ORDER: begin
				pend_d = 1'b0;
				if (db > da) begin
					x_d     = y_q;
					y_d     = x_q;
					delta_d = LEVELS'(db - da);
				end else begin
					delta_d = LEVELS'(da - db);
				end
			end
			ACT_Q_LIFT: begin
				x_d         = lift_a;
				anc_re_a    = delta_q[lvl];
				anc_ra_node = lift_a;
				pend_d      = delta_q[lvl];
			end
			ACT_Q_SETTLE: begin
				x_d    = lift_a;
				pend_d = 1'b0;
			end
			ACT_Q_CLIMB: begin
				x_d         = climb_a;
				y_d         = climb_b;
				anc_re_a    = 1'b1;
				anc_re_b    = 1'b1;
				anc_ra_node = climb_a;
				anc_rb_node = climb_b;
				pend_d      = 1'b1;
			end
			ACT_Q_PARENT: begin
				x_d         = climb_a;
				y_d         = climb_b;
				anc_re_a    = 1'b1;
				anc_ra_node = climb_a;
				anc_rlvl    = '0;
				pend_d      = 1'b0;
			end
			ACT_Q_TAKE: begin
				x_d = ra;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= in_a;
			y_q <= in_b;
		end else begin
			x_q <= x_d;
			y_q <= y_d;
		end
		delta_q <= delta_d;
	end

	always_ff @(posedge clk) begin
		if (anc_we) begin
			anc_mem[{AW'(x_q), anc_wlvl}] <= anc_wd;
		end
		if (anc_re_a) begin
			anc_rd_a_q <= anc_mem[{AW'(anc_ra_node), anc_rlvl}];
			anc_za_q   <= (anc_ra_node == '0);
		end
		if (anc_re_b) begin
			anc_rd_b_q <= anc_mem[{AW'(anc_rb_node), anc_rlvl}];
			anc_zb_q   <= (anc_rb_node == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (dep_we) begin
			dep_mem[AW'(x_q)] <= dep_wd;
		end
		if (dep_re) begin
			dep_rd_a_q <= dep_mem[AW'(dep_ra_node)];
			dep_za_q   <= (dep_ra_node == '0);
			dep_rd_b_q <= dep_mem[AW'(dep_rb_node)];
			dep_zb_q   <= (dep_rb_node == '0);
		end
	end

endmodule

// ===== hw/rtl/tree_lowest_common_ancestor.sv =====
// Tree LCA by binary lifting. A load writes the node's depth and ancestor row,
// level by level. A query lifts the deeper node, then climbs both nodes (skipped
// when the lifted node meets the other), each pass from the top level down. The
// next item is taken only after the result is registered for the output.
// Reset clears the sequencer and output valid; the memories are not cleared.
module tree_lowest_common_ancestor
	import tlca_pkg::*;
#(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // node_a [9:0], node_b [19:10], zero [23:20]
	input  logic [0:0]  s_tuser,   // op [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // ancestor [9:0], zero [15:10]
);

	localparam int LW = $clog2(LEVELS);

	logic              accept;
	logic              out_free;
	logic              emit;
	logic              idle;
	act_t              act;
	logic [LW-1:0]     lvl;
	dp_stat_t          stat;
	logic [NODE_W-1:0] result;
	logic [NODE_W-1:0] node_a, node_b;
	logic              out_valid_q;
	logic [NODE_W-1:0] out_data_q;

	// Out-of-range node numbers fold to the null node
	assign node_a = (32'(s_tdata[NODE_W-1:0]) < NODES) ? s_tdata[NODE_W-1:0] : '0;
	assign node_b = (32'(s_tdata[2*NODE_W-1:NODE_W]) < NODES) ?
		s_tdata[2*NODE_W-1:NODE_W] : '0;

	assign s_tready = idle;
	assign accept   = s_tvalid && idle;
	assign out_free = !out_valid_q || m_tready;
	assign emit     = (act == ACT_EMIT) && out_free;

	tlca_seq #(
		.LEVELS(LEVELS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (s_tuser[0]),
		.out_free(out_free),
		.stat    (stat),
		.act     (act),
		.lvl     (lvl),
		.idle    (idle)
	);

	tlca_dp #(
		.NODES (NODES),
		.LEVELS(LEVELS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (accept),
		.in_a  (node_a),
		.in_b  (node_b),
		.act   (act),
		.lvl   (lvl),
		.stat  (stat),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_data_q};

endmodule

// ===== verif/tree_lowest_common_ancestor_test.sv =====
`timescale 1ns / 100ps
// Testbench of tree_lowest_common_ancestor: loads trees, asks lowest common ancestors and
// checks each answer against a binary-lifting predictor held in a scoreboard class.
// Depends on tlca_pkg and the block's RTL only.
module tree_lowest_common_ancestor_test;

	localparam int NODES        = 1024;
	localparam int LEVELS       = 10;
	localparam int NW           = tlca_pkg::NODE_W;
	localparam int DW           = tlca_pkg::DEPTH_W;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TAIL_CYCLES  = 2*LEVELS + 10;
	localparam int PHASE_ITEMS  = 15;
	localparam int WRAP_BUMPS   = 1030;
	localparam int RECENT_DEPTH = 8;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef logic [NW-1:0] node_t;

	class tree_scoreboard;
		logic [DW-1:0] depth_of [NODES];
		node_t jump [NODES][LEVELS];
		node_t expected_ancestors [$];
		int errors;

		function new();
			foreach (depth_of[v]) depth_of[v] = '0;
			foreach (jump[v, j]) jump[v][j] = '0;
			errors = 0;
		endfunction

		// Build the new row from the old entries first, then write, so a self parent works
		function void add_node(node_t v, node_t p);
			node_t row [LEVELS];
			logic [DW-1:0] d;
			if (v == '0)
				return;
			d = (p == '0) ? DW'(1) : depth_of[p] + DW'(1);
			row[0] = p;
			for (int j = 1; j < LEVELS; j++)
				row[j] = jump[row[j-1]][j-1];
			depth_of[v] = d;
			for (int j = 0; j < LEVELS; j++)
				jump[v][j] = row[j];
		endfunction

		function node_t common_ancestor(node_t a, node_t b);
			node_t x, y, t;
			logic [DW-1:0] delta;
			x = a;
			y = b;
			if (depth_of[y] > depth_of[x]) begin
				t = x;
				x = y;
				y = t;
			end
			delta = depth_of[x] - depth_of[y];
			for (int i = LEVELS - 1; i >= 0; i--)
				if (i < DW && delta[i])
					x = jump[x][i];
			if (x == y)
				return x;
			for (int i = LEVELS - 1; i >= 0; i--) begin
				if (jump[x][i] != jump[y][i]) begin
					x = jump[x][i];
					y = jump[y][i];
				end
			end
			return jump[x][0];
		endfunction

		function void note_transfer(op_t op, node_t a, node_t b);
			if (op == OP_LOAD)
				add_node(a, b);
			else
				expected_ancestors = {expected_ancestors, common_ancestor(a, b)};
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_ancestor(node_t got);
			node_t want;
			if (expected_ancestors.size() == 0) begin
				report($sformatf("ancestor %0d arrived with nothing expected", got));
			end else begin
				want = expected_ancestors.pop_front();
				if (got !== want)
					report($sformatf("ancestor %0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // node_a [9:0], node_b [19:10], zero [23:20]
	logic [0:0]  s_tuser  = '0;   // op [0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // ancestor [9:0], zero [15:10]

	tree_scoreboard board = new();

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cycles      = 0;

	bit    is_loaded [NODES];
	node_t loaded_nodes [$];
	node_t recent_nodes [$];

	tree_lowest_common_ancestor #(
		.NODES  (NODES),
		.LEVELS (LEVELS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_ancestor(m_tdata[NW-1:0]);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tree_lowest_common_ancestor verification failed");
			$finish;
		end
	end

	// Valid stays high from one transfer to the next unless the sender idles
	task automatic send_item(op_t op, node_t a, node_t b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_transfer(op, a, b);
	endtask

	task automatic load_node(node_t a, node_t b);
		send_item(OP_LOAD, a, b);
		if (!is_loaded[a]) begin
			is_loaded[a] = 1'b1;
			loaded_nodes = {loaded_nodes, a};
		end
		recent_nodes = {recent_nodes, a};
		if (recent_nodes.size() > RECENT_DEPTH)
			void'(recent_nodes.pop_front());
	endtask

	// Hold the sender until every outstanding answer is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (board.expected_ancestors.size() != 0);
	endtask

	// Favor recently loaded nodes so that long chains grow
	function automatic node_t pick_node();
		if ($urandom_range(1) == 1)
			return recent_nodes[$urandom_range(recent_nodes.size() - 1)];
		return loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
	endfunction

	task automatic random_item();
		node_t a, b;
		int roll;
		if ($urandom_range(99) < 2)
			drain_results();
		roll = $urandom_range(99);
		if (roll < 45) begin
			a = node_t'($urandom_range(NODES - 1, 1));
			roll = $urandom_range(99);
			if (roll < 8)
				b = '0;
			else if (roll < 14 && is_loaded[a])
				b = a;
			else
				b = pick_node();
			load_node(a, b);
		end else begin
			a = pick_node();
			roll = $urandom_range(99);
			if (roll < 5)
				b = '0;
			else if (roll < 15)
				b = a;
			else
				b = pick_node();
			send_item(OP_QUERY, a, b);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 32;
		rx_idle_pct = 78;

		// Two trees, extremes of the node numbers
		load_node(10'd1, 10'd0);
		load_node(10'd1023, 10'd1);
		load_node(10'd2, 10'd1023);
		load_node(10'd512, 10'd2);
		load_node(10'd3, 10'd1);
		load_node(10'd4, 10'd0);
		load_node(10'd5, 10'd4);
		send_item(OP_QUERY, 10'd1, 10'd1);
		send_item(OP_QUERY, 10'd1023, 10'd1023);
		send_item(OP_QUERY, 10'd512, 10'd1023);
		send_item(OP_QUERY, 10'd512, 10'd3);
		send_item(OP_QUERY, 10'd3, 10'd512);
		send_item(OP_QUERY, 10'd512, 10'd5);
		send_item(OP_QUERY, 10'd2, 10'd0);
		send_item(OP_QUERY, 10'd1, 10'd1023);
		// Self parent, then restore and move a node to the other tree
		load_node(10'd3, 10'd3);
		send_item(OP_QUERY, 10'd3, 10'd512);
		send_item(OP_QUERY, 10'd512, 10'd3);
		load_node(10'd3, 10'd1);
		load_node(10'd5, 10'd1023);
		send_item(OP_QUERY, 10'd5, 10'd512);
		send_item(OP_QUERY, 10'd5, 10'd1);

		// Bump one node on itself until its depth wraps past the top
		load_node(10'd1000, 10'd512);
		for (int i = 1; i <= WRAP_BUMPS; i++) begin
			load_node(10'd1000, 10'd1000);
			if (i % 128 == 0 || (i >= 1016 && i <= 1021))
				send_item(OP_QUERY, 10'd1000, (i % 2 == 1) ? 10'd512 : 10'd1);
		end
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 32;
					rx_idle_pct = 78;
				end
				1: begin
					tx_idle_pct = 78;
					rx_idle_pct = 32;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item();
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.expected_ancestors.size() == 0)
			$display("tree_lowest_common_ancestor verification clean");
		else
			$display("tree_lowest_common_ancestor verification failed");
		$finish;
	end

endmodule
